[rtl/core/gcb_pkg.sv]
`timescale 1ns / 1ps
package gcb_pkg;

    // channel index 2 is red, 1 green, 0 blue, matching the 0xAARRGGBB layout
    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_DIRECT = 2'd1,
        K_EMPTY  = 2'd2,
        K_BLEND  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_DRAW_COLOR    = 3'd0,
        REG_GRAY_LEVELS   = 3'd1,
        REG_MONO_MODE     = 3'd2,
        REG_PREMULT       = 3'd3,
        REG_X_OFFSET      = 3'd4,
        REG_Y_OFFSET      = 3'd5,
        REG_TARGET_WIDTH  = 3'd6,
        REG_TARGET_HEIGHT = 3'd7
    } t_reg_idx;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [31:0] RST_DRAW_COLOR  = 32'hFF00_0000;
    localparam logic [8:0]  RST_GRAY_LEVELS = 9'd256;
    localparam logic [10:0] RST_TARGET_SIZE = 11'd1024;

    typedef struct packed {
        logic [31:0]        draw_color;
        logic [8:0]         max_cov;
        logic               mono_mode;
        logic               premultiplied;
        logic signed [10:0] x_offset;
        logic signed [10:0] y_offset;
        logic [10:0]        target_width;
        logic [10:0]        target_height;
    } t_cfg;

    typedef struct packed {
        t_kind           kind;
        logic [7:0]      cov;
        logic [2:0][7:0] dst_c;
        logic [7:0]      dst_a;
    } t_pix;

    // floor(p / 255), exact for p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

[rtl/core/gcb_in_if.sv]
`timescale 1ns / 1ps
interface gcb_in_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] src_x;
    logic [COORD_BITS-1:0] src_y;
    logic [7:0]            src_value;
    logic [7:0]            dst_red;
    logic [7:0]            dst_green;
    logic [7:0]            dst_blue;
    logic [7:0]            dst_alpha;

    modport source (
        output valid, src_x, src_y, src_value, dst_red, dst_green, dst_blue, dst_alpha,
        input  ready
    );
    modport sink (
        input  valid, src_x, src_y, src_value, dst_red, dst_green, dst_blue, dst_alpha,
        output ready
    );
endinterface

[rtl/core/gcb_out_if.sv]
`timescale 1ns / 1ps
interface gcb_out_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic                  write_enable;
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic [7:0]            out_alpha;

    modport source (
        output valid, write_enable, target_x, target_y, out_red, out_green, out_blue,
               out_alpha,
        input  ready
    );
    modport sink (
        input  valid, write_enable, target_x, target_y, out_red, out_green, out_blue,
               out_alpha,
        output ready
    );
endinterface

[rtl/core/glyph_coverage_blend_rgba_unit.sv]
`timescale 1ns / 1ps
// glyph pixel blender for rgba8 targets: takes one glyph pixel per clock (coverage plus the
// destination pixel read back) and returns one result per pixel, in order, with write_enable
// low for uncovered or clipped pixels. sustained rate is one pixel per clock when the output
// is not stalled. the pipelined restoring dividers take 24 stages for coverage and
// unpremultiply and 8 for the straight alpha divide. a 4-entry queue between classification
// and the arithmetic pipeline absorbs short output stalls. write configuration only while no
// transaction is in flight.
module glyph_coverage_blend_rgba_unit import gcb_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gcb_in_if.sink                i_in,
    gcb_out_if.source             o_out
);
    localparam int QW = 2 * COORD_BITS + $bits(t_pix);

    logic [31:0]        r_draw_color;
    logic [8:0]         r_gray_levels;
    logic               r_mono_mode;
    logic               r_premult;
    logic signed [10:0] r_x_offset;
    logic signed [10:0] r_y_offset;
    logic [10:0]        r_target_width;
    logic [10:0]        r_target_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color    <= RST_DRAW_COLOR;
            r_gray_levels   <= RST_GRAY_LEVELS;
            r_mono_mode     <= 1'b0;
            r_premult       <= 1'b0;
            r_x_offset      <= '0;
            r_y_offset      <= '0;
            r_target_width  <= RST_TARGET_SIZE;
            r_target_height <= RST_TARGET_SIZE;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DRAW_COLOR:    r_draw_color    <= i_cfg_data;
                REG_GRAY_LEVELS:   r_gray_levels   <= i_cfg_data[8:0];
                REG_MONO_MODE:     r_mono_mode     <= i_cfg_data[0];
                REG_PREMULT:       r_premult       <= i_cfg_data[0];
                REG_X_OFFSET:      r_x_offset      <= i_cfg_data[10:0];
                REG_Y_OFFSET:      r_y_offset      <= i_cfg_data[10:0];
                REG_TARGET_WIDTH:  r_target_width  <= i_cfg_data[10:0];
                REG_TARGET_HEIGHT: r_target_height <= i_cfg_data[10:0];
                default:           r_mono_mode     <= r_mono_mode;
            endcase
        end
    end

    t_cfg cfg;

    always_comb begin
        cfg.draw_color    = r_draw_color;
        cfg.max_cov       = (r_gray_levels > 9'd1) ? r_gray_levels - 9'd1 : 9'd1;
        cfg.mono_mode     = r_mono_mode;
        cfg.premultiplied = r_premult;
        cfg.x_offset      = r_x_offset;
        cfg.y_offset      = r_y_offset;
        cfg.target_width  = r_target_width;
        cfg.target_height = r_target_height;
    end

    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_valid;
    t_pix                  f_pix;
    logic [COORD_BITS-1:0] f_tx;
    logic [COORD_BITS-1:0] f_ty;
    logic [QW-1:0]         q_out;
    t_pix                  b_pix;
    logic [COORD_BITS-1:0] b_tx;
    logic [COORD_BITS-1:0] b_ty;

    gcb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_cfg    (cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_pix    (f_pix),
        .o_tx     (f_tx),
        .o_ty     (f_ty)
    );

    gcb_queue #(.DATA_W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_tx, f_ty, f_pix}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_tx, b_ty, b_pix} = q_out;

    gcb_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_pix     (b_pix),
        .i_tx      (b_tx),
        .i_ty      (b_ty),
        .o_pop     (pop),
        .o_out     (o_out)
    );

`ifndef NO_ASSERTIONS
    // a skipped pixel carries no coordinates and no colour
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.write_enable |->
            o_out.target_x == '0 && o_out.target_y == '0 && o_out.out_alpha == 8'h00
            && o_out.out_red == 8'h00 && o_out.out_green == 8'h00 && o_out.out_blue == 8'h00)
        else $error("skipped pixel with nonzero fields");

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // the queue is never drained while empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
`endif
endmodule

[rtl/core/gcb_div.sv]
`timescale 1ns / 1ps
module gcb_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 9,
    parameter int QUO_W = 24
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    // restoring division, one quotient bit per stage, msb first
    // quotient must fit in QUO_W bits
    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CW-1:0]    r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W-1];

    for (genvar s = 0; s < QUO_W; s++) begin : g_st
        logic [CW-1:0]    rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CW-1:0]    sub;
        logic             fits;
        logic [CW-1:0]    n_rem;
        logic [QUO_W-1:0] n_quo;

        if (s == 0) begin : g_first
            assign rem_in = CW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign sub   = CW'(den_in) << (QUO_W - 1 - s);
        assign fits  = rem_in >= sub;
        assign n_rem = fits ? rem_in - sub : rem_in;
        assign n_quo = quo_in | (fits ? (QUO_W'(1) << (QUO_W - 1 - s)) : '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
            end
        end

        if (s < QUO_W - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];
endmodule

[rtl/core/gcb_front.sv]
`timescale 1ns / 1ps
module gcb_front import gcb_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  t_cfg                  i_cfg,
    gcb_in_if.sink                i_in,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_pix                  o_pix,
    output logic [COORD_BITS-1:0] o_tx,
    output logic [COORD_BITS-1:0] o_ty
);
    localparam int TW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;
    localparam logic signed [TW-1:0] LIMIT = TW'(1) << COORD_BITS;

    logic signed [TW-1:0] tx;
    logic signed [TW-1:0] ty;
    logic                 covered;
    logic                 clipped;
    logic [2:0]           bit_sel;

    assign bit_sel = 3'd7 - i_in.src_x[2:0];
    assign covered = i_cfg.mono_mode ? i_in.src_value[bit_sel] : (i_in.src_value != 8'd0);

    assign tx = $signed({{(TW-COORD_BITS){1'b0}}, i_in.src_x}) + TW'(i_cfg.x_offset);
    assign ty = $signed({{(TW-COORD_BITS){1'b0}}, i_in.src_y}) + TW'(i_cfg.y_offset);

    assign clipped = tx[TW-1] || ty[TW-1]
                  || (tx >= $signed({{(TW-11){1'b0}}, i_cfg.target_width}))
                  || (ty >= $signed({{(TW-11){1'b0}}, i_cfg.target_height}))
                  || (tx >= LIMIT) || (ty >= LIMIT);

    always_comb begin
        o_pix.cov   = i_in.src_value;
        o_pix.dst_c = {i_in.dst_red, i_in.dst_green, i_in.dst_blue};
        o_pix.dst_a = i_in.dst_alpha;
        if (!covered || clipped) begin
            o_pix.kind = K_NONE;
        end else if (i_cfg.mono_mode) begin
            o_pix.kind = K_DIRECT;
        end else if ((9'(i_in.src_value) == i_cfg.max_cov)
                     && (i_cfg.draw_color[31:24] == 8'hFF)) begin
            o_pix.kind = K_DIRECT;
        end else if (i_in.dst_alpha == 8'd0) begin
            o_pix.kind = K_EMPTY;
        end else begin
            o_pix.kind = K_BLEND;
        end
    end

    assign o_tx       = tx[COORD_BITS-1:0];
    assign o_ty       = ty[COORD_BITS-1:0];
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
endmodule

[rtl/core/gcb_queue.sv]
`timescale 1ns / 1ps
module gcb_queue import gcb_pkg::*; #(
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [PW:0]       r_cnt;
    logic [PW-1:0]     n_wr;
    logic [PW-1:0]     n_rd;

    assign o_full  = r_cnt == (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign n_wr    = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

[rtl/core/gcb_back.sv]
`timescale 1ns / 1ps
module gcb_back import gcb_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_q_valid,
    input  t_pix                  i_pix,
    input  logic [COORD_BITS-1:0] i_tx,
    input  logic [COORD_BITS-1:0] i_ty,
    output logic                  o_pop,
    gcb_out_if.source             o_out
);
    localparam int DIV_LAT = 24;
    localparam int FIN_LAT = 8;

    typedef struct packed {
        t_pix                  pix;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [2:0]            ult;
    } t_s1;

    typedef struct packed {
        t_pix                  pix;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [16:0]           b;
        logic [16:0]           ib;
        logic [16:0]           e;
        logic [16:0]           iexib;
        logic [7:0]            aemp;
        logic [2:0][23:0]      u;
    } t_sc;

    typedef struct packed {
        t_pix                  pix;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [16:0]           b;
        logic [16:0]           pa;
        logic [16:0]           base;
        logic [2:0][25:0]      mix;
        logic [2:0][15:0]      pe;
        logic [7:0]            aemp;
    } t_sd;

    typedef struct packed {
        t_kind                 kind;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [2:0][7:0]       fr;
        logic [7:0]            fra;
        logic [2:0]            sat;
    } t_sf;

    logic            adv;
    logic [7:0]      col_a;
    logic [2:0][7:0] col;

    assign col_a = i_cfg.draw_color[31:24];
    assign col   = i_cfg.draw_color[23:0];

    logic r_out_valid;
    assign adv   = !r_out_valid || o_out.ready;
    assign o_pop = adv && i_q_valid;

    // entry: operands for the first divider bank
    logic [23:0]      num_b;
    logic [15:0]      num_al;
    logic [2:0][31:0] num_u;
    logic [2:0]       ult;
    logic [23:0]      qb;
    logic [23:0]      qal;
    logic [2:0][23:0] qu;

    always_comb begin
        num_b  = {i_pix.cov, 16'h0000};
        num_al = 16'(col_a) * 16'(i_pix.cov);
        for (int i = 0; i < 3; i++) begin
            num_u[i] = {(16'(i_pix.dst_c[i]) << 8) - 16'(i_pix.dst_c[i]), 16'h0000};
            ult[i]   = i_pix.dst_c[i] < i_pix.dst_a;
        end
    end

    gcb_div #(.NUM_W(24), .DEN_W(9), .QUO_W(DIV_LAT)) u_div_b (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (num_b),
        .i_den (i_cfg.max_cov),
        .o_quo (qb)
    );

    gcb_div #(.NUM_W(16), .DEN_W(9), .QUO_W(DIV_LAT)) u_div_al (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (num_al),
        .i_den (i_cfg.max_cov),
        .o_quo (qal)
    );

    for (genvar g = 0; g < 3; g++) begin : g_udiv
        gcb_div #(.NUM_W(32), .DEN_W(8), .QUO_W(DIV_LAT)) u_div_u (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (num_u[g]),
            .i_den (i_pix.dst_a),
            .o_quo (qu[g])
        );
    end

    t_s1                r_s1 [DIV_LAT];
    logic [DIV_LAT-1:0] r_v1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1[0] <= '{pix: i_pix, tx: i_tx, ty: i_ty, ult: ult};
            for (int j = 1; j < DIV_LAT; j++) begin
                r_s1[j] <= r_s1[j-1];
            end
        end
    end

    // stage c: saturate quotients, destination alpha in q16
    t_s1  s1;
    t_sc  n_c;
    t_sc  r_c;
    logic r_vc;

    assign s1 = r_s1[DIV_LAT-1];

    always_comb begin
        logic [33:0] prod;
        logic [16:0] ie;
        n_c.pix  = s1.pix;
        n_c.tx   = s1.tx;
        n_c.ty   = s1.ty;
        n_c.b    = (qb > 24'(ONE_Q16)) ? ONE_Q16 : qb[16:0];
        n_c.ib   = ONE_Q16 - n_c.b;
        n_c.e    = {1'b0, s1.pix.dst_a, 8'h00} + 17'(s1.pix.dst_a)
                 + 17'(s1.pix.dst_a == 8'hFF);
        ie       = ONE_Q16 - n_c.e;
        prod     = 34'(ie) * 34'(n_c.ib);
        n_c.iexib = prod[32:16];
        n_c.aemp = (qal > 24'd255) ? 8'hFF : qal[7:0];
        for (int i = 0; i < 3; i++) begin
            n_c.u[i] = s1.ult[i] ? qu[i] : 24'hFF_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c <= n_c;
        end
    end

    // stage d: combined alpha, straight base weight, premultiplied mix
    t_sd  n_d;
    t_sd  r_d;
    logic r_vd;

    always_comb begin
        logic [33:0] pbase;
        logic [40:0] pm;
        n_d.pix  = r_c.pix;
        n_d.tx   = r_c.tx;
        n_d.ty   = r_c.ty;
        n_d.b    = r_c.b;
        n_d.aemp = r_c.aemp;
        n_d.pa   = ONE_Q16 - r_c.iexib;
        pbase    = 34'(r_c.ib) * 34'(r_c.e);
        n_d.base = pbase[32:16];
        pm       = '0;
        for (int i = 0; i < 3; i++) begin
            pm         = 41'(r_c.u[i]) * 41'(r_c.ib);
            n_d.mix[i] = 26'(26'(col[i]) * 26'(r_c.b)) + 26'(pm[40:16]);
            n_d.pe[i]  = 16'(col[i]) * 16'(r_c.aemp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d <= n_d;
        end
    end

    // stage e: finished values for every path but the straight blend
    t_sf              n_e;
    t_sf              r_e;
    logic [2:0][25:0] n_num;
    logic [2:0][25:0] r_num;
    logic [16:0]      r_pa;
    logic             r_ve;

    always_comb begin
        logic [24:0] t;
        logic [42:0] pmx;
        logic [7:0]  ba;
        logic [7:0]  pm_res;
        logic [7:0]  ec;
        logic [7:0]  pc;
        t      = (25'(r_d.pa) << 8) - 25'(r_d.pa);
        ba     = t[23:16];
        pmx    = '0;
        pm_res = '0;
        ec     = '0;
        pc     = '0;
        n_e.kind = r_d.pix.kind;
        n_e.tx   = r_d.tx;
        n_e.ty   = r_d.ty;
        for (int i = 0; i < 3; i++) begin
            pmx      = 43'(r_d.mix[i]) * 43'(r_d.pa);
            pm_res   = (pmx[42:32] > 11'd255) ? 8'hFF : pmx[39:32];
            n_num[i] = 26'(26'(col[i]) * 26'(r_d.b))
                     + 26'(26'(r_d.pix.dst_c[i]) * 26'(r_d.base));
            n_e.sat[i] = n_num[i] >= {1'b0, r_d.pa, 8'h00};
            ec = i_cfg.premultiplied ? div255(r_d.pe[i]) : col[i];
            pc = i_cfg.premultiplied ? div255(16'(col[i]) * 16'(col_a)) : col[i];
            case (r_d.pix.kind)
                K_DIRECT: n_e.fr[i] = pc;
                K_EMPTY:  n_e.fr[i] = ec;
                K_BLEND:  n_e.fr[i] = pm_res;
                default:  n_e.fr[i] = 8'h00;
            endcase
        end
        case (r_d.pix.kind)
            K_DIRECT: n_e.fra = col_a;
            K_EMPTY:  n_e.fra = r_d.aemp;
            K_BLEND:  n_e.fra = ba;
            default:  n_e.fra = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e   <= n_e;
            r_num <= n_num;
            r_pa  <= r_d.pa;
        end
    end

    // straight blend divides by the combined alpha, limited to 255 beforehand
    logic [2:0][7:0] qf;

    for (genvar g = 0; g < 3; g++) begin : g_fdiv
        gcb_div #(.NUM_W(26), .DEN_W(17), .QUO_W(FIN_LAT)) u_div_f (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r_e.sat[g] ? 26'd0 : r_num[g]),
            .i_den (r_pa),
            .o_quo (qf[g])
        );
    end

    t_sf                r_f [FIN_LAT];
    logic [FIN_LAT-1:0] r_vf;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f[0] <= r_e;
            for (int j = 1; j < FIN_LAT; j++) begin
                r_f[j] <= r_f[j-1];
            end
        end
    end

    // output register
    t_sf                   sf;
    logic                  r_we;
    logic [COORD_BITS-1:0] r_tx;
    logic [COORD_BITS-1:0] r_ty;
    logic [2:0][7:0]       r_ch;
    logic [7:0]            r_a;
    logic [2:0][7:0]       n_ch;
    logic                  straight;

    assign sf       = r_f[FIN_LAT-1];
    assign straight = (sf.kind == K_BLEND) && !i_cfg.premultiplied;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (straight) begin
                n_ch[i] = sf.sat[i] ? 8'hFF : qf[i];
            end else begin
                n_ch[i] = sf.fr[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_we <= sf.kind != K_NONE;
            r_tx <= (sf.kind != K_NONE) ? sf.tx : '0;
            r_ty <= (sf.kind != K_NONE) ? sf.ty : '0;
            r_ch <= n_ch;
            r_a  <= sf.fra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= '0;
            r_vc        <= 1'b0;
            r_vd        <= 1'b0;
            r_ve        <= 1'b0;
            r_vf        <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= {r_v1[DIV_LAT-2:0], i_q_valid};
            r_vc        <= r_v1[DIV_LAT-1];
            r_vd        <= r_vc;
            r_ve        <= r_vd;
            r_vf        <= {r_vf[FIN_LAT-2:0], r_ve};
            r_out_valid <= r_vf[FIN_LAT-1];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.write_enable = r_we;
    assign o_out.target_x     = r_tx;
    assign o_out.target_y     = r_ty;
    assign o_out.out_red      = r_ch[2];
    assign o_out.out_green    = r_ch[1];
    assign o_out.out_blue     = r_ch[0];
    assign o_out.out_alpha    = r_a;
endmodule
